/* hdl/biquad_tdf2_filter_unit_assert.svh */
// assertion macros for the biquad filter rtl
// both expect signals named clk and rst_n in the module that uses them
`ifndef BIQUAD_TDF2_FILTER_UNIT_ASSERT_SVH
`define BIQUAD_TDF2_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define BQF_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BQF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bqf_pkg.sv */
// ----------------------------------------------------------------------------
// bqf_pkg
// types and constants shared by the biquad filter controller and datapath
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = 3;

  // coefficient register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } coef_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_ACC_B0,
    ST_ACC_B1,
    ST_ACC_A1,
    ST_ACC_B2,
    ST_ACC_A2,
    ST_DONE
  } state_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_B0_X,
    MUL_B1_X,
    MUL_A1_Y,
    MUL_B2_X,
    MUL_A2_Y
  } mul_sel_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_OUT,     // b0*x + delay_one + half, round and clamp to y
    ACC_ADD_D2,  // acc = b1*x + delay_two
    ACC_SUB_D1,  // delay_one = sat(acc - a1*y)
    ACC_LOAD,    // acc = b2*x
    ACC_SUB_D2   // delay_two = sat(acc - a2*y)
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     load_out;
  } cmd_t;

endpackage

/* hdl/bqf_ifs.sv */
// ----------------------------------------------------------------------------
// bqf stream interfaces
// valid/ready channels for input samples and filtered results
// ----------------------------------------------------------------------------
interface bqf_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface bqf_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;
  logic                           last_out;

  modport source (output valid, output sample_out, output clipped, output last_out,
                  input ready);
  modport sink   (input valid, input sample_out, input clipped, input last_out,
                  output ready);
endinterface

/* hdl/bqf_ctrl.sv */
// ----------------------------------------------------------------------------
// bqf_ctrl
// sequencer for the five products and the output register handshake
// ----------------------------------------------------------------------------
`include "biquad_tdf2_filter_unit_assert.svh"

module bqf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bqf_pkg::cmd_t cmd
);

  bqf_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.mul_sel   = bqf_pkg::MUL_NONE;
    cmd.acc_op    = bqf_pkg::ACC_NONE;
    cmd.load_out  = 1'b0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      bqf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bqf_pkg::ST_MUL_B0;
        end
      end
      bqf_pkg::ST_MUL_B0: begin
        cmd.mul_sel = bqf_pkg::MUL_B0_X;
        state_nxt   = bqf_pkg::ST_ACC_B0;
      end
      bqf_pkg::ST_ACC_B0: begin
        cmd.acc_op  = bqf_pkg::ACC_OUT;
        cmd.mul_sel = bqf_pkg::MUL_B1_X;
        state_nxt   = bqf_pkg::ST_ACC_B1;
      end
      bqf_pkg::ST_ACC_B1: begin
        cmd.acc_op  = bqf_pkg::ACC_ADD_D2;
        cmd.mul_sel = bqf_pkg::MUL_A1_Y;
        state_nxt   = bqf_pkg::ST_ACC_A1;
      end
      bqf_pkg::ST_ACC_A1: begin
        cmd.acc_op  = bqf_pkg::ACC_SUB_D1;
        cmd.mul_sel = bqf_pkg::MUL_B2_X;
        state_nxt   = bqf_pkg::ST_ACC_B2;
      end
      bqf_pkg::ST_ACC_B2: begin
        cmd.acc_op  = bqf_pkg::ACC_LOAD;
        cmd.mul_sel = bqf_pkg::MUL_A2_Y;
        state_nxt   = bqf_pkg::ST_ACC_A2;
      end
      bqf_pkg::ST_ACC_A2: begin
        cmd.acc_op = bqf_pkg::ACC_SUB_D2;
        state_nxt  = bqf_pkg::ST_DONE;
      end
      bqf_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bqf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bqf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `BQF_ASSERT_NXT(a_accept_starts_seq, in_valid && in_ready, state_r == bqf_pkg::ST_MUL_B0, "accepted sample did not start the product sequence")
  `BQF_ASSERT_IMM(a_load_slot_free, cmd.load_out, !out_valid_r || out_ready, "result loaded over an untaken result")
  `BQF_ASSERT_IMM(a_valid_from_done, $rose(out_valid_r), $past(state_r) == bqf_pkg::ST_DONE, "result valid raised outside the final step")

endmodule

/* hdl/bqf_datapath.sv */
// ----------------------------------------------------------------------------
// bqf_datapath
// coefficient registers, shared multiplier, accumulator, delay state, output register
// ----------------------------------------------------------------------------
module bqf_datapath #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_WIDTH     = 32,
  parameter int COEF_FRAC_BITS = 28,
  parameter int STATE_WIDTH    = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bqf_pkg::cmd_t                          cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
  input  logic                                   in_last,
  input  logic                                   cfg_we,
  input  logic        [bqf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [COEF_WIDTH-1:0]           cfg_data,
  output logic signed [SAMPLE_WIDTH-1:0]         out_sample,
  output logic                                   out_clipped,
  output logic                                   out_last
);

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int AW = ((PW > STATE_WIDTH) ? PW : STATE_WIDTH) + 2;

  localparam logic signed [AW-1:0] Y_MAX =
    {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [AW-1:0] S_MAX =
    {{(AW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] S_MIN = ~S_MAX;
  localparam logic signed [AW-1:0] HALF  =
    {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0] UNITY = COEF_WIDTH'(1) << COEF_FRAC_BITS;

  logic signed [COEF_WIDTH-1:0]   coef_r [bqf_pkg::NUM_COEF];
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r, y_nxt;
  logic                           last_r;
  logic                           clip_r, clip_nxt;
  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic signed [AW-1:0]           acc_r;
  logic signed [AW-1:0]           acc_sum;
  logic signed [AW-1:0]           shifted;
  logic signed [AW-1:0]           sat_val;
  logic                           sat_hit;
  logic                           y_hit;
  logic signed [STATE_WIDTH-1:0]  d1_r, d2_r;
  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;

  // configuration writes, index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[bqf_pkg::REG_B0] <= UNITY;
      coef_r[bqf_pkg::REG_B1] <= '0;
      coef_r[bqf_pkg::REG_B2] <= '0;
      coef_r[bqf_pkg::REG_A1] <= '0;
      coef_r[bqf_pkg::REG_A2] <= '0;
    end else if (cfg_we && (cfg_index < bqf_pkg::CFG_IDX_W'(bqf_pkg::NUM_COEF))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = coef_r[bqf_pkg::REG_B0];
    mul_b = x_r;
    case (cmd.mul_sel)
      bqf_pkg::MUL_B1_X: begin
        mul_a = coef_r[bqf_pkg::REG_B1];
      end
      bqf_pkg::MUL_A1_Y: begin
        mul_a = coef_r[bqf_pkg::REG_A1];
        mul_b = y_r;
      end
      bqf_pkg::MUL_B2_X: begin
        mul_a = coef_r[bqf_pkg::REG_B2];
      end
      bqf_pkg::MUL_A2_Y: begin
        mul_a = coef_r[bqf_pkg::REG_A2];
        mul_b = y_r;
      end
      default: begin
        mul_a = coef_r[bqf_pkg::REG_B0];
      end
    endcase
    prod_nxt = PW'(mul_a) * PW'(mul_b);
  end

  // accumulator adder
  always_comb begin
    case (cmd.acc_op)
      bqf_pkg::ACC_OUT:    acc_sum = AW'(prod_r) + AW'(d1_r) + HALF;
      bqf_pkg::ACC_ADD_D2: acc_sum = AW'(prod_r) + AW'(d2_r);
      bqf_pkg::ACC_LOAD:   acc_sum = AW'(prod_r);
      bqf_pkg::ACC_SUB_D1,
      bqf_pkg::ACC_SUB_D2: acc_sum = acc_r - AW'(prod_r);
      default:             acc_sum = acc_r;
    endcase
  end

  // output rounding (floor after half add) and clamp
  always_comb begin
    shifted = acc_sum >>> COEF_FRAC_BITS;
    y_hit   = 1'b1;
    if (shifted > Y_MAX) begin
      y_nxt = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (shifted < Y_MIN) begin
      y_nxt = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_nxt = shifted[SAMPLE_WIDTH-1:0];
      y_hit = 1'b0;
    end
  end

  // state clamp
  always_comb begin
    sat_hit = 1'b1;
    if (acc_sum > S_MAX) begin
      sat_val = S_MAX;
    end else if (acc_sum < S_MIN) begin
      sat_val = S_MIN;
    end else begin
      sat_val = acc_sum;
      sat_hit = 1'b0;
    end
  end

  always_comb begin
    clip_nxt = clip_r;
    case (cmd.acc_op)
      bqf_pkg::ACC_OUT:    clip_nxt = clip_r | y_hit;
      bqf_pkg::ACC_SUB_D1,
      bqf_pkg::ACC_SUB_D2: clip_nxt = clip_r | sat_hit;
      default:             clip_nxt = clip_r;
    endcase
    if (cmd.capture) begin
      clip_nxt = 1'b0;
    end
  end

  // delay state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      if (cmd.acc_op == bqf_pkg::ACC_SUB_D1) begin
        d1_r <= sat_val[STATE_WIDTH-1:0];
      end
      if (cmd.acc_op == bqf_pkg::ACC_SUB_D2) begin
        d2_r <= sat_val[STATE_WIDTH-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    clip_r <= clip_nxt;
    if (cmd.capture) begin
      x_r    <= in_sample;
      last_r <= in_last;
    end
    if (cmd.mul_sel != bqf_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_op == bqf_pkg::ACC_ADD_D2 || cmd.acc_op == bqf_pkg::ACC_LOAD) begin
      acc_r <= acc_sum;
    end
    if (cmd.acc_op == bqf_pkg::ACC_OUT) begin
      y_r <= y_nxt;
    end
    if (cmd.load_out) begin
      out_sample  <= y_r;
      out_clipped <= clip_r;
      out_last    <= last_r;
    end
  end

endmodule

/* hdl/biquad_tdf2_filter_unit.sv */
// samples are accepted only while the sequencer is idle, and each result is
//   loaded for output before the next sample is taken; the single shared
//   multiplier steps through b0*x, b1*x, a1*y, b2*x and a2*y between capture
//   and output load; a stalled result holds the sequencer in its last step
// reset (rst_n low, synchronous): delay state cleared, coefficients set to
//   pass-through (b0 = 1.0, others 0), no result pending
// ----------------------------------------------------------------------------
// biquad_tdf2_filter_unit
// second-order iir section, transposed direct form ii, fixed point
// ----------------------------------------------------------------------------
module biquad_tdf2_filter_unit #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_WIDTH     = 32,
  parameter int COEF_FRAC_BITS = 28,
  parameter int STATE_WIDTH    = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input samples, one transaction per sample
  bqf_in_if.sink                              in_if,
  // filtered samples, exactly one transaction per input
  bqf_out_if.source                           out_if,
  // coefficient write port, b0 b1 b2 a1 a2 at indexes 0 to 4
  input  logic                                cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_WIDTH-1:0]               cfg_data
);

  // command bundle from the sequencer to the datapath
  bqf_pkg::cmd_t cmd;

  // controller: accepts a sample only when idle, steps the five products,
  // then hands the result to the output register once it is free
  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // datapath: coefficients, one registered multiplier, wide accumulator,
  // rounding and saturation, the two delay registers and the result register
  bqf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_sample   (in_if.sample_in),
    .in_last     (in_if.last_in),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_sample  (out_if.sample_out),
    .out_clipped (out_if.clipped),
    .out_last    (out_if.last_out)
  );

endmodule

/* sim/biquad_tdf2_filter_unit_test.sv */
// ----------------------------------------------------------------------------
// biquad_tdf2_filter_unit_test
// self-checking bench for the transposed direct form ii biquad section:
// streams samples through the valid/ready channels under several coefficient
// sets, predicts every filtered sample in a scoreboard class and compares
// sample, clip flag and last flag of each result transaction in order
// ----------------------------------------------------------------------------
module biquad_tdf2_filter_unit_test;

  localparam int SW  = 16;  // sample width, q1.15
  localparam int CW  = 32;  // coefficient width, q4.28
  localparam int FB  = 28;  // coefficient fraction bits
  localparam int STW = 48;  // delay state width

  // one filtered sample as seen on the result channel
  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clipped;
    logic                 last;
  } filtered_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of coefficients and delay state, queue of
  // filtered samples still owed by the block
  // --------------------------------------------------------------------------
  class biquad_scoreboard;
    longint    b0, b1, b2, a1, a2;
    longint    d1, d2;
    filtered_t pending_filtered[$];
    int        n_errors;

    function new();
      b0 = longint'(1) <<< FB;
      b1 = 0;
      b2 = 0;
      a1 = 0;
      a2 = 0;
      d1 = 0;
      d2 = 0;
      n_errors = 0;
    endfunction

    function void set_coef(logic [bqf_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
      longint c;
      c = $signed(val);
      case (idx)
        bqf_pkg::REG_B0: b0 = c;
        bqf_pkg::REG_B1: b1 = c;
        bqf_pkg::REG_B2: b2 = c;
        bqf_pkg::REG_A1: a1 = c;
        bqf_pkg::REG_A2: a2 = c;
        default: ;  // no such register, write dropped
      endcase
    endfunction

    function longint clamp_to(longint v, int w, inout bit hit);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (v < lo) begin
        hit = 1'b1;
        return lo;
      end
      return v;
    endfunction

    // one tdf2 step: y from b0*x + d1, then both delays from x and y
    function filtered_t filter_sample(logic signed [SW-1:0] xs, logic last);
      filtered_t r;
      longint    x, acc, y, n1, n2;
      bit        hit;
      hit = 1'b0;
      x   = xs;
      acc = b0 * x + d1 + (longint'(1) <<< (FB - 1));
      y   = clamp_to(acc >>> FB, SW, hit);  // floor shift, ties go up
      n1  = b1 * x - a1 * y + d2;
      n2  = b2 * x - a2 * y;
      d1  = clamp_to(n1, STW, hit);
      d2  = clamp_to(n2, STW, hit);
      r.sample  = y[SW-1:0];
      r.clipped = hit;
      r.last    = last;
      return r;
    endfunction

    function void take_sample(logic signed [SW-1:0] xs, logic last);
      pending_filtered.push_back(filter_sample(xs, last));
    endfunction

    function void check_output(logic signed [SW-1:0] s, logic clipped, logic last);
      filtered_t want;
      if (pending_filtered.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: result sample %0d clipped %0b last %0b with none owed",
                   s, clipped, last);
        return;
      end
      want = pending_filtered.pop_front();
      if (want.sample !== s || want.clipped !== clipped || want.last !== last) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: expected sample %0d clipped %0b last %0b, got %0d %0b %0b",
                   want.sample, want.clipped, want.last, s, clipped, last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bqf_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  bqf_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  logic                          cfg_we;
  logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]                 cfg_data;

  biquad_tdf2_filter_unit #(
    .SAMPLE_WIDTH  (SW),
    .COEF_WIDTH    (CW),
    .COEF_FRAC_BITS(FB),
    .STATE_WIDTH   (STW)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  biquad_scoreboard sb;

  // --------------------------------------------------------------------------
  // result side: check every transaction, stall on a rotating pattern,
  // and once hold ready low for a long stretch so the block backs up
  // --------------------------------------------------------------------------
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int stall_tick   = 0;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_output(out_ch.sample_out, out_ch.clipped, out_ch.last_out);
      results_seen++;
    end
    stall_tick++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      // long hold-off, sender keeps offering meanwhile
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen == 150) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ch.ready <= 1'b0;
    end else begin
      // patterns rotate through open, coin flip, 1 in 8 and 1 in 4
      case ((stall_tick >> 6) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (stall_tick % 8 == 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input side tasks
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // offer one sample and wait for its transaction
  task automatic send_sample(logic signed [SW-1:0] x, logic last);
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    in_ch.last_in   <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_sample(x, last);
  endtask

  // bursts of back-to-back samples with random gaps in between
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every owed result is back and the sequencer is idle again
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_filtered.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_coef(logic [bqf_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_coef(idx, val);
  endtask

  task automatic write_coef_set(logic [CW-1:0] nb0, logic [CW-1:0] nb1,
                                logic [CW-1:0] nb2, logic [CW-1:0] na1,
                                logic [CW-1:0] na2);
    write_coef(bqf_pkg::REG_B0, nb0);
    write_coef(bqf_pkg::REG_B1, nb1);
    write_coef(bqf_pkg::REG_B2, nb2);
    write_coef(bqf_pkg::REG_A1, na1);
    write_coef(bqf_pkg::REG_A2, na2);
    cfg_we <= 1'b0;
  endtask

  // indexes past a2 do not exist and must leave the coefficients alone
  task automatic write_unused_indexes();
    // let the write enable drop after a preceding write set
    @(posedge clk);
    for (int i = bqf_pkg::NUM_COEF; i < (1 << bqf_pkg::CFG_IDX_W); i++)
      write_coef(bqf_pkg::CFG_IDX_W'(i), $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'h1000_0000;   // +1.0
      default: return 32'hf000_0000;  // -1.0
    endcase
  endfunction

  // new coefficient set: raw random, moderate, damped low-pass-like or extremes
  task automatic write_random_set();
    int nb0, nb1, nb2, na1, na2;
    case ($urandom_range(0, 3))
      0: begin
        nb0 = $urandom; nb1 = $urandom; nb2 = $urandom; na1 = $urandom; na2 = $urandom;
      end
      1: begin
        nb0 = $urandom_range(0, 1 << 29) - (1 << 28);
        nb1 = $urandom_range(0, 1 << 29) - (1 << 28);
        nb2 = $urandom_range(0, 1 << 29) - (1 << 28);
        na1 = $urandom_range(0, 1 << 29) - (1 << 28);
        na2 = $urandom_range(0, 1 << 29) - (1 << 28);
      end
      2: begin
        // poles near the unit circle, a1 in -1.95..-1.5, a2 in 0.6..0.95
        nb0 = $urandom_range(0, 1 << 22);
        nb1 = 2 * nb0;
        nb2 = nb0;
        na1 = -int'($urandom_range(402653184, 523449139));
        na2 = $urandom_range(161061274, 255013683);
      end
      default: begin
        nb0 = pick_extreme(); nb1 = pick_extreme(); nb2 = pick_extreme();
        na1 = pick_extreme(); na2 = pick_extreme();
      end
    endcase
    write_coef_set(nb0, nb1, nb2, na1, na2);
    if ($urandom_range(0, 2) == 0)
      write_unused_indexes();
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12)
      return SW'($urandom);
    if (pick < 15)
      return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
    return SW'($urandom_range(0, 512) - 256);
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [SW-1:0] pass_vals[8];
    logic signed [SW-1:0] tie_vals[4];
    sb = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.last_in   = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients pass samples straight through
    pass_vals = '{16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff,
                  16'sh8000, 16'sh5555, 16'shaaaa, 16'sh3039};
    foreach (pass_vals[i]) begin
      send_sample(pass_vals[i], i[0]);
      pace();
    end
    settle();

    // b0 = 0.5: odd samples land exactly on a half, rounding goes up
    write_coef_set(32'h0800_0000, '0, '0, '0, '0);
    tie_vals = '{16'sh0001, 16'shffff, 16'sh0003, 16'shfffd};
    foreach (tie_vals[i]) begin
      send_sample(tie_vals[i], 1'b0);
      pace();
    end
    settle();

    // all coefficients at the positive end: output and state clamp
    write_coef_set(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    settle();

    // all coefficients at the negative end
    write_coef_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    settle();

    // writes to unused indexes change nothing
    write_coef_set(32'h1000_0000, '0, '0, '0, '0);
    write_unused_indexes();
    send_sample(16'sh1234, 1'b0);
    send_sample(16'shedcb, 1'b1);
    settle();

    // random part: eight coefficient sets, 150 samples each
    for (int p = 0; p < 8; p++) begin
      write_random_set();
      for (int n = 0; n < 150; n++) begin
        send_sample(rand_sample(), ($urandom_range(0, 7) == 0));
        pace();
      end
      settle();
    end

    repeat (16) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending_filtered.size() == 0)
      $display("biquad_tdf2_filter_unit_test: clean");
    else
      $display("biquad_tdf2_filter_unit_test: errors");
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #1600000;
    $display("biquad_tdf2_filter_unit_test: errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/bqf_pkg.sv
hdl/bqf_ifs.sv
hdl/bqf_ctrl.sv
hdl/bqf_datapath.sv
hdl/biquad_tdf2_filter_unit.sv
sim/biquad_tdf2_filter_unit_test.sv
